FILE: rtl/core/rmth_pkg.sv
// Package for the running median block: sizes, sample type, heap select and
// the command and status records shared by the controller and the datapath.
// No dependencies.
package rmth_pkg;

  localparam int CAPACITY     = 1024;
  localparam int SAMPLE_WIDTH = 32;
  localparam int HALF_CAP     = (CAPACITY + 1) / 2;
  localparam int AW           = $clog2(HALF_CAP);
  localparam int CW           = $clog2(HALF_CAP + 1);
  localparam int HW           = $clog2(CAPACITY + 1);
  localparam int MW           = SAMPLE_WIDTH + 1;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

  typedef enum logic {
    HEAP_LO = 1'b0,
    HEAP_UP = 1'b1
  } heap_e;

  typedef struct packed {
    logic  load_x;
    logic  push_start;
    logic  push_src_tmp;
    logic  sift_start;
    heap_e heap;
    logic  up_read;
    logic  up_move;
    logic  dn_read;
    logic  dn_move;
    logic  place;
    logic  set_ovf;
    logic  out_load;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic lower_big;
    logic gt_lo;
    logic lt_up;
    logic idx_zero;
    logic up_above;
    logic dn_self;
  } stat_t;

endpackage

FILE: rtl/core/rmth_datapath.sv
// Datapath of the running median block: both heap memories, the heap tops,
// the counts, the sift index and the result register.
// Depends on rmth_pkg.
module rmth_datapath import rmth_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sample_t           sample_i,
  input  cmd_t              cmd_i,
  output stat_t             stat_o,
  output logic [MW-1:0]     median_doubled_o,
  output logic [HW-1:0]     held_count_o,
  output logic              overflow_o
);

  sample_t lo_mem [HALF_CAP];
  sample_t up_mem [HALF_CAP];

  sample_t        x_q, val_q, tmp_q, lo_top_q, up_top_q;
  sample_t        lo_a_q, lo_b_q, up_a_q, up_b_q;
  logic [AW-1:0]  idx_q;
  heap_e          sel_q;
  logic [CW-1:0]  lc_q, uc_q;
  logic           ovf_q;
  logic [MW-1:0]  med_q;
  logic [HW-1:0]  held_q;
  logic           ovf_out_q;

  function automatic logic above(sample_t a, sample_t b, heap_e h);
    return (h == HEAP_LO) ? (a > b) : (a < b);
  endfunction

  logic [AW-1:0]  parent;
  logic [AW:0]    lidx;
  logic [AW+1:0]  ridx;
  logic [AW+1:0]  n_ext;
  logic           l_ok, r_ok, pick_l, pick_r;
  sample_t        hd_a, hd_b, best_v, child_v, wdata;
  logic [AW-1:0]  ra_a, ra_b, child_i;
  logic           we;
  logic [HW-1:0]  held;
  logic signed [MW-1:0] med_d;

  assign parent  = (idx_q - AW'(1)) >> 1;
  assign lidx    = {idx_q, 1'b1};
  assign ridx    = {1'b0, lidx} + (AW+2)'(1);
  assign n_ext   = (AW+2)'((sel_q == HEAP_LO) ? lc_q : uc_q);
  assign l_ok    = {1'b0, lidx} < n_ext;
  assign r_ok    = ridx < n_ext;
  assign hd_a    = (sel_q == HEAP_LO) ? lo_a_q : up_a_q;
  assign hd_b    = (sel_q == HEAP_LO) ? lo_b_q : up_b_q;
  assign pick_l  = l_ok && above(hd_a, val_q, sel_q);
  assign best_v  = pick_l ? hd_a : val_q;
  assign pick_r  = r_ok && above(hd_b, best_v, sel_q);
  assign child_v = pick_r ? hd_b : hd_a;
  assign child_i = pick_r ? ridx[AW-1:0] : lidx[AW-1:0];
  assign ra_a    = cmd_i.up_read ? parent : lidx[AW-1:0];
  assign ra_b    = ridx[AW-1:0];
  assign we      = cmd_i.place | cmd_i.up_move | cmd_i.dn_move;
  assign held    = HW'(lc_q) + HW'(uc_q);

  always_comb begin
    if (cmd_i.place) begin
      wdata = val_q;
    end else if (cmd_i.up_move) begin
      wdata = hd_a;
    end else begin
      wdata = child_v;
    end
  end

  always_comb begin
    if (lc_q == '0) begin
      med_d = '0;
    end else if (lc_q > uc_q) begin
      med_d = {lo_top_q, 1'b0};
    end else begin
      med_d = MW'(lo_top_q) + MW'(up_top_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (we && sel_q == HEAP_LO) begin
      lo_mem[idx_q] <= wdata;
    end
    lo_a_q <= lo_mem[ra_a];
    lo_b_q <= lo_mem[ra_b];
  end

  always_ff @(posedge clk_i) begin
    if (we && sel_q == HEAP_UP) begin
      up_mem[idx_q] <= wdata;
    end
    up_a_q <= up_mem[ra_a];
    up_b_q <= up_mem[ra_b];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_x) begin
      x_q <= sample_i;
    end
    if (cmd_i.push_start) begin
      val_q <= cmd_i.push_src_tmp ? tmp_q : x_q;
      idx_q <= (cmd_i.heap == HEAP_LO) ? lc_q[AW-1:0] : uc_q[AW-1:0];
      sel_q <= cmd_i.heap;
    end else if (cmd_i.sift_start) begin
      val_q <= x_q;
      idx_q <= '0;
      sel_q <= cmd_i.heap;
      tmp_q <= (cmd_i.heap == HEAP_LO) ? lo_top_q : up_top_q;
    end else if (cmd_i.up_move) begin
      idx_q <= parent;
    end else if (cmd_i.dn_move) begin
      idx_q <= child_i;
    end
    if (we && idx_q == '0) begin
      if (sel_q == HEAP_LO) begin
        lo_top_q <= wdata;
      end else begin
        up_top_q <= wdata;
      end
    end
    if (cmd_i.out_load) begin
      med_q     <= med_d;
      held_q    <= held;
      ovf_out_q <= ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lc_q  <= '0;
      uc_q  <= '0;
      ovf_q <= 1'b0;
    end else begin
      if (cmd_i.push_start) begin
        if (cmd_i.heap == HEAP_LO) begin
          lc_q <= lc_q + CW'(1);
        end else begin
          uc_q <= uc_q + CW'(1);
        end
      end
      if (cmd_i.load_x) begin
        ovf_q <= 1'b0;
      end else if (cmd_i.set_ovf) begin
        ovf_q <= 1'b1;
      end
    end
  end

  assign stat_o.full      = held >= HW'(CAPACITY);
  assign stat_o.empty     = lc_q == '0;
  assign stat_o.lower_big = lc_q > uc_q;
  assign stat_o.gt_lo     = x_q > lo_top_q;
  assign stat_o.lt_up     = x_q < up_top_q;
  assign stat_o.idx_zero  = idx_q == '0;
  assign stat_o.up_above  = above(val_q, hd_a, sel_q);
  assign stat_o.dn_self   = !pick_l && !pick_r;

  assign median_doubled_o = med_q;
  assign held_count_o     = held_q;
  assign overflow_o       = ovf_out_q;

  a_lower_not_smaller: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lc_q >= uc_q) else $error("upper heap larger than lower heap");
  a_balanced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lc_q - uc_q) <= CW'(1)) else $error("heaps out of balance");
  a_within_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held <= HW'(CAPACITY)) else $error("held count above capacity");

endmodule

FILE: rtl/core/rmth_ctrl.sv
// Controller of the running median block: sequences the heap insert, the
// sift steps and the result handshake.
// Depends on rmth_pkg.
module rmth_ctrl import rmth_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_PLAN   = 8'b0000_0010,
    S_UP_RD  = 8'b0000_0100,
    S_UP_CMP = 8'b0000_1000,
    S_DN_RD  = 8'b0001_0000,
    S_DN_CMP = 8'b0010_0000,
    S_PUSH2  = 8'b0100_0000,
    S_OUT    = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   pend_q, pend_d;
  heap_e  pheap_q, pheap_d;
  logic   ovalid_q, ovalid_d;
  state_e done_st;

  assign done_st = pend_q ? S_PUSH2 : S_OUT;

  always_comb begin
    cmd_o    = '0;
    state_d  = state_q;
    pend_d   = pend_q;
    pheap_d  = pheap_q;
    ovalid_d = ovalid_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_x = 1'b1;
          state_d      = S_PLAN;
        end
      end
      S_PLAN: begin
        priority if (stat_i.full) begin
          cmd_o.set_ovf = 1'b1;
          state_d       = S_OUT;
        end else if (stat_i.empty) begin
          cmd_o.push_start = 1'b1;
          cmd_o.heap       = HEAP_LO;
          state_d          = S_UP_RD;
        end else if (stat_i.lower_big && stat_i.gt_lo) begin
          cmd_o.push_start = 1'b1;
          cmd_o.heap       = HEAP_UP;
          state_d          = S_UP_RD;
        end else if (stat_i.lower_big) begin
          cmd_o.sift_start = 1'b1;
          cmd_o.heap       = HEAP_LO;
          pend_d           = 1'b1;
          pheap_d          = HEAP_UP;
          state_d          = S_DN_RD;
        end else if (stat_i.lt_up) begin
          cmd_o.push_start = 1'b1;
          cmd_o.heap       = HEAP_LO;
          state_d          = S_UP_RD;
        end else begin
          cmd_o.sift_start = 1'b1;
          cmd_o.heap       = HEAP_UP;
          pend_d           = 1'b1;
          pheap_d          = HEAP_LO;
          state_d          = S_DN_RD;
        end
      end
      S_UP_RD: begin
        if (stat_i.idx_zero) begin
          cmd_o.place = 1'b1;
          state_d     = done_st;
        end else begin
          cmd_o.up_read = 1'b1;
          state_d       = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (stat_i.up_above) begin
          cmd_o.up_move = 1'b1;
          state_d       = S_UP_RD;
        end else begin
          cmd_o.place = 1'b1;
          state_d     = done_st;
        end
      end
      S_DN_RD: begin
        cmd_o.dn_read = 1'b1;
        state_d       = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (stat_i.dn_self) begin
          cmd_o.place = 1'b1;
          state_d     = done_st;
        end else begin
          cmd_o.dn_move = 1'b1;
          state_d       = S_DN_RD;
        end
      end
      S_PUSH2: begin
        cmd_o.push_start   = 1'b1;
        cmd_o.push_src_tmp = 1'b1;
        cmd_o.heap         = pheap_q;
        pend_d             = 1'b0;
        state_d            = S_UP_RD;
      end
      S_OUT: begin
        if (!ovalid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          ovalid_d       = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      pend_q   <= 1'b0;
      pheap_q  <= HEAP_LO;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      pend_q   <= pend_d;
      pheap_q  <= pheap_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = ovalid_q;

endmodule

FILE: rtl/core/running_median_two_heaps.sv
// Running median over the beats kept since reset, in a max-heap and a min-heap.
// Depends on rmth_pkg, rmth_ctrl and rmth_datapath.
// Each sift level reads through the registered heap memory read port; a beat may take
// a sift-down and then a push with sift-up. Once CAPACITY beats are held, a new beat
// is not kept and its result carries the overflow flag. One beat is in work at a time;
// a result waits in the output register. Reset clears counts and handshake state.
module running_median_two_heaps import rmth_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,  // [31:0] sample
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o   // [32:0] median_doubled, [43:33] held_count,
                                       // [44] overflow, [47:45] zero
);

  cmd_t           cmd;
  stat_t          stat;
  logic [MW-1:0]  med;
  logic [HW-1:0]  held;
  logic           ovf;

  rmth_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  rmth_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .sample_i         (s_axis_tdata_i[SAMPLE_WIDTH-1:0]),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .median_doubled_o (med),
    .held_count_o     (held),
    .overflow_o       (ovf)
  );

  assign m_axis_tdata_o = {3'b000, ovf, held, med};

endmodule
